// ===== design/pdsq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the per-destination sorted queues unit
// no dependencies

package pdsq_pkg;

	localparam int QID_W      = 4;
	localparam int KEY_W      = 16;
	localparam int TAG_PORT_W = 32;
	localparam int FILL_OUT_W = 5;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REQ_INSERT = 1'b0,
		REQ_POP    = 1'b1
	} req_t;

endpackage

// ===== design/pdsq_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module pdsq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/per_destination_sorted_queues_unit.sv =====
`timescale 1ns / 1ps
// per-destination sorted queues: one bounded queue per destination, kept in key order
// depends on pdsq_pkg and pdsq_ram
//
// channel  dir  fields (lowest bit up)
// s_axis   in   tuser: req_type | tdata: queue_id, seq_number, command_tag, pad
// m_axis   out  tuser: status   | tdata: seq_out, tag_out, fill_level, pad
//
// one request at a time; the queue memory has one read and one write port
// insert: a non-empty queue is scanned from its tail, larger keys moving up one slot,
// until the sorted position is found; an empty queue is written directly, a full one refused
// pop: the head is returned and the rest move down a slot, one entry moved per cycle
// reset clears the fill counts at once; the entry memory needs no clearing
// a finished result waits in the output register while the next request is taken

module per_destination_sorted_queues_unit import pdsq_pkg::*; #(
	parameter int NUM_QUEUES  = 10,
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // queue_id[3:0], seq_number[19:4], command_tag[51:20]
	input  logic [0:0]  s_axis_tuser,  // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // seq_out[15:0], tag_out[47:16], fill_level[52:48]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int NUM_ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int TW_KEEP     = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;
	localparam int ENTRY_W     = KEY_W + TAG_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_INS_SCAN,
		S_INS_PUT,
		S_POP_HEAD,
		S_POP_SHIFT,
		S_RESP
	} state_t;

	state_t state_q;

	logic [FILL_W-1:0] fill_q [NUM_QUEUES];

	req_t                  req_q;
	logic                  qok_q;
	logic [QIDX_W-1:0]     qidx_q;
	logic signed [KEY_W-1:0] key_q;
	logic [TAG_WIDTH-1:0]  tag_q;
	logic [FILL_W-1:0]     n_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [ADDR_W-1:0]     base_q;

	status_t               res_status_q;
	logic [KEY_W-1:0]      res_seq_q;
	logic [TAG_PORT_W-1:0] res_tag_q;
	logic [FILL_W-1:0]     res_fill_q;

	logic [QID_W-1:0]      qid_in;
	logic [QIDX_W-1:0]     qidx_in;
	logic                  qok_in;

	logic                  ram_we;
	logic [SLOT_W-1:0]     wr_slot;
	logic [ENTRY_W-1:0]    ram_wr_data;
	logic [ADDR_W-1:0]     ram_wr_addr;
	logic                  ram_rd_en;
	logic [SLOT_W-1:0]     rd_slot;
	logic [ADDR_W-1:0]     ram_rd_addr;
	logic [ENTRY_W-1:0]    ram_rd_data;
	logic signed [KEY_W-1:0] rd_key;
	logic [TAG_WIDTH-1:0]  rd_tag;
	logic [ENTRY_W-1:0]    new_entry;
	logic                  take;

	assign qid_in  = s_axis_tdata[QID_W-1:0];
	assign qidx_in = QIDX_W'(qid_in);
	assign qok_in  = (32'(qid_in) < NUM_QUEUES);

	assign s_axis_tready = (state_q == S_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;

	assign rd_key    = ram_rd_data[KEY_W-1:0];
	assign rd_tag    = ram_rd_data[ENTRY_W-1:KEY_W];
	assign new_entry = {tag_q, key_q};

	assign ram_wr_addr = base_q + ADDR_W'(wr_slot);
	assign ram_rd_addr = base_q + ADDR_W'(rd_slot);

	always_comb begin
		ram_we      = 1'b0;
		wr_slot     = '0;
		ram_wr_data = new_entry;
		ram_rd_en   = 1'b0;
		rd_slot     = '0;
		unique case (state_q)
			S_START: begin
				if (qok_q && req_q == REQ_POP && n_q != '0) begin
					ram_rd_en = 1'b1;
				end else if (qok_q && req_q == REQ_INSERT
						&& n_q != FILL_W'(QUEUE_DEPTH)) begin
					if (n_q == '0) begin
						ram_we = 1'b1;
					end else begin
						ram_rd_en = 1'b1;
						rd_slot   = SLOT_W'(n_q - FILL_W'(1));
					end
				end
			end
			S_INS_SCAN: begin
				ram_we  = 1'b1;
				wr_slot = idx_q;
				if (rd_key > key_q) begin
					ram_wr_data = ram_rd_data;
					if (idx_q != SLOT_W'(1)) begin
						ram_rd_en = 1'b1;
						rd_slot   = idx_q - SLOT_W'(2);
					end
				end
			end
			S_INS_PUT: begin
				ram_we = 1'b1;
			end
			S_POP_HEAD: begin
				if (n_q != FILL_W'(1)) begin
					ram_rd_en = 1'b1;
					rd_slot   = SLOT_W'(1);
				end
			end
			S_POP_SHIFT: begin
				ram_we      = 1'b1;
				wr_slot     = idx_q - SLOT_W'(1);
				ram_wr_data = ram_rd_data;
				if (FILL_W'(idx_q) != n_q - FILL_W'(1)) begin
					ram_rd_en = 1'b1;
					rd_slot   = idx_q + SLOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	pdsq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_ENTRIES)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			m_axis_tvalid <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_RESP) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						req_q   <= req_t'(s_axis_tuser[0]);
						qok_q   <= qok_in;
						qidx_q  <= qidx_in;
						key_q   <= s_axis_tdata[QID_W +: KEY_W];
						tag_q   <= TAG_WIDTH'(s_axis_tdata[QID_W + KEY_W +: TW_KEEP]);
						n_q     <= qok_in ? fill_q[qidx_in] : '0;
						base_q  <= ADDR_W'(32'(qidx_in) * QUEUE_DEPTH);
						state_q <= S_START;
					end
				end
				S_START: begin
					res_seq_q <= '0;
					res_tag_q <= '0;
					if (!qok_q) begin
						res_status_q <= (req_q == REQ_POP) ? ST_EMPTY : ST_FULL;
						res_fill_q   <= '0;
						state_q      <= S_RESP;
					end else if (req_q == REQ_POP) begin
						if (n_q == '0) begin
							res_status_q <= ST_EMPTY;
							res_fill_q   <= n_q;
							state_q      <= S_RESP;
						end else begin
							fill_q[qidx_q] <= n_q - FILL_W'(1);
							res_status_q   <= ST_DONE;
							res_fill_q     <= n_q - FILL_W'(1);
							state_q        <= S_POP_HEAD;
						end
					end else if (n_q == FILL_W'(QUEUE_DEPTH)) begin
						res_status_q <= ST_FULL;
						res_fill_q   <= n_q;
						state_q      <= S_RESP;
					end else begin
						fill_q[qidx_q] <= n_q + FILL_W'(1);
						res_status_q   <= ST_DONE;
						res_fill_q     <= n_q + FILL_W'(1);
						idx_q          <= SLOT_W'(n_q);
						state_q        <= (n_q == '0) ? S_RESP : S_INS_SCAN;
					end
				end
				S_INS_SCAN: begin
					if (rd_key > key_q) begin
						idx_q <= idx_q - SLOT_W'(1);
						if (idx_q == SLOT_W'(1)) begin
							state_q <= S_INS_PUT;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_INS_PUT: begin
					state_q <= S_RESP;
				end
				S_POP_HEAD: begin
					res_seq_q <= rd_key;
					res_tag_q <= TAG_PORT_W'(rd_tag[TW_KEEP-1:0]);
					idx_q     <= SLOT_W'(1);
					state_q   <= (n_q == FILL_W'(1)) ? S_RESP : S_POP_SHIFT;
				end
				S_POP_SHIFT: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (FILL_W'(idx_q) == n_q - FILL_W'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= res_status_q;
						m_axis_tdata  <= {3'b000, FILL_OUT_W'(res_fill_q), res_tag_q, res_seq_q};
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// no entry is read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_rd_en && ram_wr_addr == ram_rd_addr))
		else $error("queue memory read and write collide");

	// failed requests return no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata[47:0] == '0))
		else $error("entry returned with an error status");

	// the addressed queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && qok_q) |-> (fill_q[qidx_q] <= FILL_W'(QUEUE_DEPTH)))
		else $error("queue fill above depth");

	// the scan always finds the sorted position before walking off the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_SCAN) |-> (idx_q != '0))
		else $error("insert scan below the queue head");

endmodule
